[design/bole_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and codes of the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int BOLE_CAPACITY = 16;

  localparam int CMD_W  = 4;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD_BACK     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_FRONT    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT_AT    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_BACK  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT = 4'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FIND         = 4'd6;
  localparam logic [CMD_W-1:0] CMD_READ_AT      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CLEAR        = 4'd8;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CHECK,
    FSM_SCAN,
    FSM_LAST,
    FSM_DONE
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic write_last;
    logic finish;
  } bole_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic need_last;
    logic ins_pend;
    logic scan_done;
    logic out_free;
  } bole_sts_t;

endpackage
`default_nettype wire

[design/bole_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bole_ctrl
// Sequencer of the list engine: accepts an item, steps the datapath through
// check, memory walk, final write and result hand-off.
// ----------------------------------------------------------------------------
module bole_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bole_pkg::bole_sts_t sts,
  output bole_pkg::bole_cmd_t     cmd
);
  import bole_pkg::*;

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = FSM_CHECK;
        end
      end
      FSM_CHECK: begin
        cmd.check = 1'b1;
        if (sts.need_scan) begin
          state_nxt = FSM_SCAN;
        end else if (sts.need_last) begin
          state_nxt = FSM_LAST;
        end else begin
          state_nxt = FSM_DONE;
        end
      end
      FSM_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sts.ins_pend ? FSM_LAST : FSM_DONE;
        end
      end
      FSM_LAST: begin
        cmd.write_last = 1'b1;
        state_nxt      = FSM_DONE;
      end
      FSM_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/bole_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bole_dp
// Datapath of the list engine: entry memory, count, walk pointer with a
// registered read stage, command checks and the result register.
// ----------------------------------------------------------------------------
module bole_dp #(
  parameter int CAPACITY = bole_pkg::BOLE_CAPACITY
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bole_pkg::bole_cmd_t               cmd,
  output bole_pkg::bole_sts_t                    sts,
  input  wire logic [bole_pkg::CMD_W-1:0]        in_command,
  input  wire logic signed [bole_pkg::DATA_W-1:0] in_data_in,
  input  wire logic [bole_pkg::POS_W-1:0]        in_position,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [bole_pkg::DATA_W-1:0]     out_data_out,
  output logic [bole_pkg::POS_W-1:0]             out_found_position,
  output logic                                   out_found,
  output logic [bole_pkg::POS_W-1:0]             out_count,
  output logic [bole_pkg::STAT_W-1:0]            out_status
);
  import bole_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Entry memory: one write and one registered read per cycle.
  logic [DATA_W-1:0] mem_r [CAPACITY];
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              rd_en;
  logic [DATA_W-1:0] rd_data_r;

  // Item and walk state.
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [POS_W-1:0]  pos_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     lim_r, lim_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              dir_dn_r, dir_dn_nxt;
  logic              rd_act_r, rd_act_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]     rd_addr_r;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic              ins_pend_r, ins_pend_nxt;
  logic              found_r, found_nxt;
  logic [POS_W-1:0]  fpos_r, fpos_nxt;
  logic [DATA_W-1:0] dout_r, dout_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Check-stage decode.
  logic [PW-1:0]     n_ext, p_ext, idx_w;
  logic              full, empty;
  logic              cls_add, cls_rem, cls_read, cls_find;
  logic [STAT_W-1:0] chk_st;
  logic              chk_ok, need_scan, need_last;
  logic              match;
  logic [AW:0]       fpos_w;

  assign n_ext = PW'(count_r);
  assign p_ext = PW'(pos_r);
  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    cls_add  = 1'b0;
    cls_rem  = 1'b0;
    cls_read = 1'b0;
    cls_find = 1'b0;
    chk_st   = STAT_OK;
    idx_w    = '0;
    unique case (cmd_r) inside
      CMD_ADD_BACK: begin
        cls_add = 1'b1;
        chk_st  = full ? STAT_FULL : STAT_OK;
        idx_w   = n_ext;
      end
      CMD_ADD_FRONT: begin
        cls_add = 1'b1;
        chk_st  = full ? STAT_FULL : STAT_OK;
      end
      CMD_INSERT_AT: begin
        cls_add = 1'b1;
        idx_w   = p_ext - PW'(1);
        if (p_ext == '0 || p_ext > n_ext + PW'(1)) begin
          chk_st = STAT_BADPOS;
        end else if (full) begin
          chk_st = STAT_FULL;
        end
      end
      CMD_REMOVE_BACK: begin
        cls_rem = 1'b1;
        chk_st  = empty ? STAT_EMPTY : STAT_OK;
        idx_w   = n_ext - PW'(1);
      end
      CMD_REMOVE_FRONT: begin
        cls_rem = 1'b1;
        chk_st  = empty ? STAT_EMPTY : STAT_OK;
      end
      CMD_REMOVE_AT, CMD_READ_AT: begin
        cls_rem  = (cmd_r == CMD_REMOVE_AT);
        cls_read = (cmd_r == CMD_READ_AT);
        idx_w    = p_ext - PW'(1);
        if (empty) begin
          chk_st = STAT_EMPTY;
        end else if (p_ext == '0 || p_ext > n_ext) begin
          chk_st = STAT_BADPOS;
        end
      end
      CMD_FIND: begin
        cls_find = 1'b1;
        chk_st   = empty ? STAT_EMPTY : STAT_OK;
      end
      default: begin
        chk_st = STAT_OK;
      end
    endcase
  end

  assign chk_ok = (chk_st == STAT_OK);
  // An add at the end needs no shift, only the final write.
  assign need_scan = chk_ok && ((cls_add && idx_w != n_ext) || cls_rem || cls_read || cls_find);
  assign need_last = chk_ok && cls_add;

  assign match  = rd_vld_r && cls_find && !found_r && (rd_data_r == val_r);
  assign fpos_w = {1'b0, rd_addr_r} + {{AW{1'b0}}, 1'b1};

  assign rd_en = cmd.scan && rd_act_r;

  // Memory write port: shifted entries during the walk, new value at the end.
  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = val_r;
    if (cmd.write_last) begin
      we = 1'b1;
    end else if (cmd.scan && rd_vld_r) begin
      if (cls_add) begin
        we    = 1'b1;
        waddr = rd_addr_r + AW'(1);
        wdata = rd_data_r;
      end else if (cls_rem && rd_addr_r != idx_r) begin
        we    = 1'b1;
        waddr = rd_addr_r - AW'(1);
        wdata = rd_data_r;
      end
    end
  end

  always_comb begin
    ptr_nxt       = ptr_r;
    lim_nxt       = lim_r;
    idx_nxt       = idx_r;
    dir_dn_nxt    = dir_dn_r;
    rd_act_nxt    = rd_act_r;
    rd_vld_nxt    = rd_en;
    st_nxt        = st_r;
    ins_pend_nxt  = ins_pend_r;
    found_nxt     = found_r;
    fpos_nxt      = fpos_r;
    dout_nxt      = dout_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      found_nxt = 1'b0;
      fpos_nxt  = '0;
      dout_nxt  = '0;
    end

    if (cmd.check) begin
      st_nxt       = chk_st;
      idx_nxt      = AW'(idx_w);
      rd_act_nxt   = need_scan;
      ins_pend_nxt = need_last;
      dir_dn_nxt   = cls_add;
      if (cls_add) begin
        ptr_nxt = AW'(n_ext - PW'(1));
        lim_nxt = AW'(idx_w);
      end else if (cls_rem) begin
        ptr_nxt = AW'(idx_w);
        lim_nxt = AW'(n_ext - PW'(1));
      end else if (cls_find) begin
        ptr_nxt = '0;
        lim_nxt = AW'(n_ext - PW'(1));
      end else begin
        ptr_nxt = AW'(idx_w);
        lim_nxt = AW'(idx_w);
      end
    end

    if (cmd.scan) begin
      if (rd_act_r) begin
        if (ptr_r == lim_r) begin
          rd_act_nxt = 1'b0;
        end else begin
          ptr_nxt = dir_dn_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
        end
      end
      if (rd_vld_r && (cls_read || (cls_rem && rd_addr_r == idx_r))) begin
        dout_nxt = rd_data_r;
      end
      if (match) begin
        found_nxt  = 1'b1;
        fpos_nxt   = POS_W'(fpos_w);
        rd_act_nxt = 1'b0;
      end
    end

    if (cmd.finish) begin
      if (cmd_r == CMD_CLEAR) begin
        count_nxt = '0;
      end else if (st_r == STAT_OK && cls_add) begin
        count_nxt = count_r + CW'(1);
      end else if (st_r == STAT_OK && cls_rem) begin
        count_nxt = count_r - CW'(1);
      end
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_act_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_act_r    <= rd_act_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      val_r <= in_data_in;
      pos_r <= in_position;
    end
    rd_addr_r  <= ptr_r;
    ptr_r      <= ptr_nxt;
    lim_r      <= lim_nxt;
    idx_r      <= idx_nxt;
    dir_dn_r   <= dir_dn_nxt;
    st_r       <= st_nxt;
    ins_pend_r <= ins_pend_nxt;
    found_r    <= found_nxt;
    fpos_r     <= fpos_nxt;
    dout_r     <= dout_nxt;
    if (cmd.finish) begin
      out_data_out       <= dout_r;
      out_found_position <= fpos_r;
      out_found          <= found_r;
      out_count          <= POS_W'(count_nxt);
      out_status         <= st_r;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.need_scan = need_scan;
  assign sts.need_last = need_last;
  assign sts.ins_pend  = ins_pend_r;
  assign sts.scan_done = (!rd_act_r && !rd_vld_r) || found_r;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule
`default_nettype wire

[design/bounded_ordered_list_engine_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top
// Ordered list of up to CAPACITY signed 32-bit values with 1-based positions.
// ----------------------------------------------------------------------------
// Usage:
//   One command item enters on the in_ channel (valid/ready) and yields
//   exactly one result item on the out_ channel (valid/ready).
//   The block works on one item at a time. Commands that need no memory walk
//   go from the check straight to the result, adds at the back through the
//   final write. Shifting inserts, removals, reads and searches walk the entry
//   memory one entry per cycle; a shifting insert then makes the final write.
//   A new item is taken the cycle after a result is loaded.
//   The result sits in an output register, so the next item is accepted
//   while an earlier result still waits. When the receiver stalls, the
//   following item finishes its work and then waits until the output
//   register is free; in_ready stays low meanwhile.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result. The entry memory itself is not cleared; entries at or above the
//   count are never read.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top #(
  parameter int CAPACITY = bole_pkg::BOLE_CAPACITY
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [bole_pkg::CMD_W-1:0]         in_command,
  input  wire logic signed [bole_pkg::DATA_W-1:0] in_data_in,
  input  wire logic [bole_pkg::POS_W-1:0]         in_position,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [bole_pkg::DATA_W-1:0]      out_data_out,
  output logic [bole_pkg::POS_W-1:0]              out_found_position,
  output logic                                    out_found,
  output logic [bole_pkg::POS_W-1:0]              out_count,
  output logic [bole_pkg::STAT_W-1:0]             out_status
);
  import bole_pkg::*;

  bole_cmd_t cmd;
  bole_sts_t sts;

  bole_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_command),
    .in_data_in         (in_data_in),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_out       (out_data_out),
    .out_found_position (out_found_position),
    .out_found          (out_found),
    .out_count          (out_count),
    .out_status         (out_status)
  );

endmodule
`default_nettype wire
